[src/md5_pkg.sv]
// MD5 stream hasher package: beat types, controller states, datapath command struct,
// round constant and shift functions. No dependencies.
`default_nettype none
package md5_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       is_last;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_beat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } ctrl_state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       store_byte;   // write req byte at current position, count it
      logic       start_block;  // load a..d from chain, clear round counter
      logic       round_step;   // run one round
      logic       fold;         // add a..d into chain
      logic       pad_mark;     // write 0x80 at position and zero the rest
      logic       pad_clear;    // zero words 0..13
      logic       pad_length;   // write bit length into words 14 and 15
      logic       restart;      // restore initial chain and clear count
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] byte_pos;     // current byte position in the block
      logic [5:0] round_idx;
   } dp_status_type;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      unique case (i)
         6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] round_s(input logic [3:0] sel);
      logic [4:0] s;
      unique case (sel)
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

[src/md5_datapath.sv]
// MD5 datapath: block buffer, chaining words, bit count and the round unit.
// Depends on md5_pkg.
`default_nettype none
module md5_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [7:0]            data_byte,
   input  wire md5_pkg::dp_cmd_type   cmd,
   output md5_pkg::dp_status_type     status,
   output logic [31:0]                chain_word [4]
);
   import md5_pkg::*;

   logic [31:0] buf_ff [16];
   logic [31:0] chain_ff [4];
   logic [63:0] count_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [5:0]  round_ff;

   logic [5:0]  pos;
   logic [1:0]  phase;
   logic [31:0] f_val, t_val, rot_val;
   logic [3:0]  g_idx;
   logic [4:0]  shamt;
   logic [63:0] rot_wide;

   assign pos   = count_ff[8:3];
   assign phase = round_ff[5:4];

   always_comb begin
      case (phase)
         2'd0: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            g_idx = round_ff[3:0];
         end
         2'd1: begin
            f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
            g_idx = 4'((round_ff[3:0] * 3'd5) + 4'd1);
         end
         2'd2: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            g_idx = 4'((round_ff[3:0] * 2'd3) + 4'd5);
         end
         default: begin
            f_val = c_ff ^ (b_ff | ~d_ff);
            g_idx = 4'(round_ff[3:0] * 3'd7);
         end
      endcase
      shamt    = round_s({phase, round_ff[1:0]});
      t_val    = a_ff + f_val + round_k(round_ff) + buf_ff[g_idx];
      rot_wide = {t_val, t_val} << shamt;
      rot_val  = rot_wide[63:32];
   end

   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         buf_ff[pos[5:2]][pos[1:0]*8 +: 8] <= data_byte;
      end
      if (cmd.pad_mark) begin
         for (int w = 0; w < 16; w++) begin
            for (int l = 0; l < 4; l++) begin
               if (6'(w*4 + l) == pos) begin
                  buf_ff[w][l*8 +: 8] <= 8'h80;
               end else if (6'(w*4 + l) > pos && !(cmd.pad_length && w >= 14)) begin
                  // leave the length words to the length write
                  buf_ff[w][l*8 +: 8] <= 8'h00;
               end
            end
         end
      end
      if (cmd.pad_clear) begin
         for (int w = 0; w < 14; w++) begin
            buf_ff[w] <= '0;
         end
      end
      if (cmd.pad_length) begin
         buf_ff[14] <= count_ff[31:0];
         buf_ff[15] <= count_ff[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '{IV0, IV1, IV2, IV3};
         count_ff <= '0;
         round_ff <= '0;
         a_ff <= '0; b_ff <= '0; c_ff <= '0; d_ff <= '0;
      end else begin
         if (cmd.store_byte) begin
            count_ff <= count_ff + 64'd8;
         end
         if (cmd.start_block) begin
            a_ff <= chain_ff[0]; b_ff <= chain_ff[1];
            c_ff <= chain_ff[2]; d_ff <= chain_ff[3];
            round_ff <= '0;
         end
         if (cmd.round_step) begin
            a_ff <= d_ff;
            d_ff <= c_ff;
            c_ff <= b_ff;
            b_ff <= b_ff + rot_val;
            round_ff <= round_ff + 6'd1;
         end
         if (cmd.fold) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
         end
         if (cmd.restart) begin
            chain_ff <= '{IV0, IV1, IV2, IV3};
            count_ff <= '0;
         end
      end
   end

   assign status.byte_pos  = pos;
   assign status.round_idx = round_ff;
   assign chain_word = chain_ff;
endmodule
`default_nettype wire

[src/md5_ctrl.sv]
// MD5 controller: sequences byte intake, compressions, padding and digest output.
// Depends on md5_pkg.
`default_nettype none
module md5_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire md5_pkg::req_beat_type  req_beat,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  word_sel,
   input  wire md5_pkg::dp_status_type status,
   output md5_pkg::dp_cmd_type         cmd
);
   import md5_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic last_ff, last_in;     // the block in flight ends the message
   logic pad2_ff, pad2_in;     // this block is the first of two pad blocks
   logic fin_ff, fin_in;       // the compression in flight is the final one
   logic [1:0] word_ff, word_in;
   logic accept;

   assign accept = req_valid && !req_stall;
   assign word_sel = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
         pad2_ff  <= 1'b0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         pad2_ff  <= pad2_in;
         word_ff  <= word_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      pad2_in   = pad2_ff;
      word_in   = word_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               cmd.store_byte = req_beat.byte_valid;
               if (req_beat.byte_valid && status.byte_pos == 6'd63) begin
                  cmd.start_block = 1'b1;
                  last_in  = req_beat.is_last;
                  state_in = ST_ROUND;
               end else if (req_beat.is_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.round_idx == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (pad2_ff) begin
               // second pad block: zeros then length
               pad2_in = 1'b0;
               cmd.pad_clear  = 1'b1;
               cmd.pad_length = 1'b1;
               state_in = ST_PAD;
            end else if (last_ff) begin
               // full data block that ends the message: pad from byte zero
               last_in  = 1'b0;
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            // chain is settled; start the next compression on padded data
            cmd.start_block = 1'b1;
            state_in = ST_ROUND;
            if (!last_ff) begin
               // first visit: mark and decide on an extra block
               cmd.pad_mark = 1'b1;
               if (status.byte_pos >= 6'd56) begin
                  last_in = 1'b1;
                  pad2_in = 1'b1;
               end else begin
                  cmd.pad_length = 1'b1;
                  last_in = 1'b0;
                  pad2_in = 1'b0;
               end
            end else begin
               last_in = 1'b0;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               word_in = word_ff + 2'd1;
               if (word_ff == 2'd3) begin
                  cmd.restart = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // final fold of a message goes to emission
      if (state_ff == ST_FOLD && !pad2_ff && !last_ff && fin_ff) begin
         state_in = ST_EMIT;
      end
   end

   always_comb begin
      fin_in = fin_ff;
      if (state_ff == ST_PAD) begin
         fin_in = !((!last_ff) && status.byte_pos >= 6'd56);
      end else if (state_ff == ST_FOLD && state_in == ST_EMIT) begin
         fin_in = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= 1'b0;
      end else begin
         fin_ff <= fin_in;
      end
   end
endmodule
`default_nettype wire

[src/md5_stream_hash.sv]
// MD5 stream hasher. Send one byte per req beat (byte_valid=0 with is_last=1 closes an
// empty tail). A byte that does not fill the 64-byte block is taken without a stall. The
// byte that fills a block stalls the input through the 64 rounds on the single round unit
// and the fold (the load rides on the accepting edge). A last beat adds padding: one or
// two further compressions (pad setup, 64 rounds, fold), then four rsp beats (word_index
// 0..3, digest words little-endian). The state then restarts from the MD5 initial values.
// No clearing pass after reset.
`default_nettype none
module md5_stream_hash (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire md5_pkg::req_beat_type req_beat,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output md5_pkg::rsp_beat_type      rsp_beat
);
   import md5_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [31:0]   chain_word [4];
   logic [1:0]    word_sel;

   md5_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_beat,
      .rsp_valid, .rsp_stall, .word_sel, .status, .cmd
   );

   md5_datapath u_dp (
      .clock, .reset, .data_byte(req_beat.data_byte), .cmd, .status, .chain_word
   );

   // drive the digest word straight from the held chain during emission
   assign rsp_beat.digest_word = chain_word[word_sel];
   assign rsp_beat.word_index  = word_sel;
   assign rsp_beat.last_word   = (word_sel == 2'd3);
endmodule
`default_nettype wire

[src/md5_stream_hash_checker.sv]
// Port-level checker for md5_stream_hash, with its bind.
// Depends on md5_pkg.
`default_nettype none
module md5_stream_hash_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire md5_pkg::rsp_beat_type rsp_beat
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
      else $error("rsp beat changed while stalled");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open during digest output");
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_beat.last_word |=> rsp_valid)
      else $error("digest words not contiguous");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_beat.last_word == (rsp_beat.word_index == 2'd3))
      else $error("last_word mismatch");
endmodule

bind md5_stream_hash md5_stream_hash_checker u_checker (.*);
`default_nettype wire

[tb/tb.sv]
// Testbench for md5_stream_hash: a directed table of messages, then random messages,
// each digest checked against a bit-level MD5 predictor. Depends on md5_pkg and the RTL.
`default_nettype none
module tb;
   import md5_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_beat_type req_beat;
   logic rsp_valid;
   logic rsp_stall;
   rsp_beat_type rsp_beat;

   md5_stream_hash dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_beat(req_beat),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_beat(rsp_beat)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Predictor state: chaining words, block buffer, bit length.
   logic [31:0] hash_chain [4];
   logic [31:0] msg_block [16];
   logic [63:0] msg_bits;
   rsp_beat_type digest_q [$];
   int errors;
   bit stim_done;
   bit hold_off;     // set by stimulus to force a long receiver stall

   localparam logic [31:0] K_TAB [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
   localparam int S_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

   // Digest of the empty message, d41d8cd98f00b204e9800998ecf8427e, as little-endian words.
   localparam logic [31:0] EMPTY_DIGEST [4] = '{
      32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};

   function automatic logic [31:0] rotl(logic [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   task automatic fold_block();
      logic [31:0] a, b, c, d, f, t;
      int g;
      a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
      for (int i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin f = (b & c) | (~b & d); g = i; end
            1: begin f = (b & d) | (c & ~d); g = 5 * i + 1; end
            2: begin f = b ^ c ^ d; g = 3 * i + 5; end
            default: begin f = c ^ (b | ~d); g = 7 * i; end
         endcase
         t = a + f + K_TAB[i] + msg_block[g % 16];
         a = d; d = c; c = b;
         b = b + rotl(t, S_TAB[(i / 16) * 4 + i % 4]);
      end
      hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
   endtask

   task automatic put_byte(int pos, logic [7:0] v);
      msg_block[pos / 4][(pos % 4) * 8 +: 8] = v;
   endtask

   task automatic restart_hash();
      hash_chain[0] = IV0; hash_chain[1] = IV1; hash_chain[2] = IV2; hash_chain[3] = IV3;
      msg_bits = '0;
   endtask

   // Advance the predictor by one accepted req beat; queue digest words on a last beat.
   task automatic predict_digest(req_beat_type b);
      int pos;
      rsp_beat_type w;
      if (b.byte_valid) begin
         pos = int'(msg_bits[8:3]);
         put_byte(pos, b.data_byte);
         msg_bits += 64'd8;
         if (pos == 63) fold_block();
      end
      if (b.is_last) begin
         pos = int'(msg_bits[8:3]);
         put_byte(pos, 8'h80);
         for (int k = pos + 1; k < 64; k++) put_byte(k, 8'h00);
         if (pos >= 56) begin
            fold_block();
            for (int k = 0; k < 14; k++) msg_block[k] = '0;
         end
         msg_block[14] = msg_bits[31:0];
         msg_block[15] = msg_bits[63:32];
         fold_block();
         for (int k = 0; k < 4; k++) begin
            w.digest_word = hash_chain[k];
            w.word_index = k[1:0];
            w.last_word = (k == 3);
            digest_q.push_back(w);
         end
         restart_hash();
      end
   endtask

   // Receiver: random stall, mostly short gaps, a few long, plus the forced hold-off.
   initial begin
      int gap;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            wait (!hold_off);
         end else begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 80) :
                  ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
            rsp_stall <= (gap != 0);
            if (gap > 1) repeat (gap - 1) @(posedge clock);
         end
      end
   end

   // Check each accepted rsp beat against the oldest queued digest word.
   int idle_cycles;
   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_q.size() == 0) begin
            $display("%0t: unexpected rsp beat, expected none, actual %h", $time, rsp_beat);
            errors++;
         end else begin
            if (rsp_beat !== digest_q[0])
               $display("%0t: mismatch expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                        digest_q[0].digest_word, digest_q[0].word_index,
                        digest_q[0].last_word, rsp_beat.digest_word,
                        rsp_beat.word_index, rsp_beat.last_word);
            if (rsp_beat !== digest_q[0]) errors++;
            void'(digest_q.pop_front());
         end
      end
      if (idle_cycles > IDLE_LIMIT) begin
         $display("** md5_stream_hash: FAILED **");
         $finish;
      end
   end

   // Offer one beat and hold it until accepted; random gap before it unless no_gap is set.
   task automatic send_beat(logic [7:0] d, logic bv, logic lst, bit no_gap);
      int gap;
      if (!no_gap) begin
         gap = ($urandom_range(0, 20) == 0) ? $urandom_range(10, 60) :
               ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_beat <= '{data_byte: d, byte_valid: bv, is_last: lst};
      do @(posedge clock); while (req_stall);
      predict_digest('{data_byte: d, byte_valid: bv, is_last: lst});
   endtask

   task automatic send_msg(int len, bit empty_tail, int fill, bit no_gap);
      logic [7:0] v;
      for (int i = 0; i < len; i++) begin
         v = (fill >= 0) ? fill[7:0] : 8'($urandom_range(0, 255));
         if (!no_gap && $urandom_range(0, 9) == 0)
            send_beat(8'($urandom), 1'b0, 1'b0, no_gap);
         send_beat(v, 1'b1, (!empty_tail && i == len - 1), no_gap);
      end
      if (empty_tail || len == 0) send_beat(8'($urandom), 1'b0, 1'b1, no_gap);
   endtask

   // Directed rows: message length, empty final beat, fill byte (-1 random).
   typedef struct { int len; bit empty_tail; int fill; } msg_row_type;
   msg_row_type dir_rows [9] = '{
      '{0, 1, -1}, '{1, 0, 0}, '{1, 0, 255}, '{55, 0, -1}, '{56, 0, -1},
      '{63, 1, -1}, '{64, 0, 255}, '{64, 1, 0}, '{3, 1, -1}};

   initial begin
      int sent;
      int len;
      errors = 0;
      stim_done = 0;
      hold_off = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_beat = '0;
      restart_hash();
      for (int k = 0; k < 16; k++) msg_block[k] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty message has a known digest; hold the predictor to it as well.
      send_beat(8'h00, 1'b0, 1'b1, 1'b0);
      req_valid <= 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (digest_q[k].digest_word !== EMPTY_DIGEST[k]) begin
            $display("%0t: empty digest word %0d expected %h actual %h", $time, k,
                     EMPTY_DIGEST[k], digest_q[k].digest_word);
            errors++;
         end
      end
      wait (digest_q.size() == 0);

      for (int r = 0; r < $size(dir_rows); r++)
         send_msg(dir_rows[r].len, dir_rows[r].empty_tail, dir_rows[r].fill, 1'b0);

      // Back-pressure: stall receiver long while the sender keeps offering.
      hold_off = 1;
      send_msg(5, 0, -1, 1'b1);
      send_msg(4, 0, -1, 1'b1);
      hold_off = 0;
      // Pause until every digest word has come.
      req_valid <= 1'b0;
      wait (digest_q.size() == 0);

      sent = 0;
      while (sent < 110) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
         send_msg(len, 1'($urandom_range(0, 1)), -1, 1'b0);
         sent += len + 1;
      end
      req_valid <= 1'b0;
      stim_done = 1;

      while (digest_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("** md5_stream_hash: PASSED **");
      else
         $display("** md5_stream_hash: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
src/md5_pkg.sv
src/md5_datapath.sv
src/md5_ctrl.sv
src/md5_stream_hash.sv
src/md5_stream_hash_checker.sv
tb/tb.sv
